@@ rtl/pfc_pkg.sv @@
// Package for the pixel format converter: format codes, register indexes,
// pipeline payload structs and the narrow-field expansion functions.
// No dependencies.
package pfc_pkg;

    localparam int PIXEL_W    = 32;
    localparam int BYTES_W    = 3;
    localparam int FMT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int LUM_SUM_W  = 18;
    localparam int RECIP_W    = 19;
    localparam int PROD_W     = LUM_SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 28;

    // ceil(2^28 / 1000): exact floor(s / 1000) for s below 2^18
    localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

    typedef enum logic [FMT_W-1:0] {
        FMT_A8R8G8B8 = 4'd0,
        FMT_X8R8G8B8 = 4'd1,
        FMT_R8G8B8   = 4'd2,
        FMT_R5G6B5   = 4'd3,
        FMT_A1R5G5B5 = 4'd4,
        FMT_X1R5G5B5 = 4'd5,
        FMT_A4R4G4B4 = 4'd6,
        FMT_A8       = 4'd7,
        FMT_L8       = 4'd8,
        FMT_A8L8     = 4'd9
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_FORMAT = 2'd0,
        REG_DEST_FORMAT   = 2'd1
    } t_reg_idx;

    typedef struct packed {
        t_fmt src_fmt;
        t_fmt dst_fmt;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [7:0]         a;
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } t_rgba;

    typedef struct packed {
        t_rgba                px;
        logic [LUM_SUM_W-1:0] sum;
    } t_lsum;

    typedef struct packed {
        t_rgba      px;
        logic [7:0] lum;
    } t_luma;

    // x * 255 / 31 = 8x + floor(7x / 31); 1/31 taken as 33/1024 on (7x + 1)
    function automatic logic [7:0] expand5(input logic [4:0] x);
        logic [7:0]  y;
        logic [12:0] m;
        y = {3'b000, x} * 8'd7;
        m = ({5'b00000, y} + 13'd1) * 13'd33;
        return {x, 3'b000} + {5'b00000, m[12:10]};
    endfunction

    // x * 255 / 63 = 4x + floor(3x / 63); 1/63 taken as 65/4096 on (3x + 1)
    function automatic logic [7:0] expand6(input logic [5:0] x);
        logic [7:0]  y;
        logic [13:0] m;
        y = {2'b00, x} * 8'd3;
        m = ({6'b000000, y} + 14'd1) * 14'd65;
        return {x, 2'b00} + {6'b000000, m[13:12]};
    endfunction

    // x * 255 / 15 = 17x
    function automatic logic [7:0] expand4(input logic [3:0] x);
        return {x, x};
    endfunction

    function automatic logic [BYTES_W-1:0] fmt_size(input t_fmt f);
        case (f)
            FMT_A8R8G8B8, FMT_X8R8G8B8:                    return 3'd4;
            FMT_R8G8B8:                                    return 3'd3;
            FMT_R5G6B5, FMT_A1R5G5B5, FMT_X1R5G5B5,
            FMT_A4R4G4B4, FMT_A8L8:                        return 3'd2;
            FMT_A8, FMT_L8:                                return 3'd1;
            default:                                       return 3'd0;
        endcase
    endfunction

endpackage

@@ rtl/pfc_if.sv @@
// Channel interfaces of the pixel format converter: source pixel stream,
// destination pixel stream and configuration write channel. Uses pfc_pkg.
interface pfc_in_if;
    logic                          valid;
    logic                          ready;
    logic [pfc_pkg::PIXEL_W-1:0]   src_pixel;
    logic                          last_in;

    modport source (output valid, output src_pixel, output last_in, input ready);
    modport sink   (input valid, input src_pixel, input last_in, output ready);
endinterface

interface pfc_out_if;
    logic                          valid;
    logic                          ready;
    logic [pfc_pkg::PIXEL_W-1:0]   dst_pixel;
    logic [pfc_pkg::BYTES_W-1:0]   dst_bytes;
    logic                          dst_written;
    logic                          last_out;

    modport source (output valid, output dst_pixel, output dst_bytes,
                    output dst_written, output last_out, input ready);
    modport sink   (input valid, input dst_pixel, input dst_bytes,
                    input dst_written, input last_out, output ready);
endinterface

interface pfc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pfc_pkg::CFG_IDX_W-1:0] index;
    logic [pfc_pkg::FMT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pixel_format_converter.sv @@
// Pixel format converter: from input transaction to result valid a pixel passes
// the expand, luminance sum, reciprocal multiply by 1/1000 and pack/output
// registers; throughput one pixel per cycle, stalls propagate stage by stage.
// Synchronous active-low reset clears all stage valid bits and sets both
// format registers to A8R8G8B8 (code 0). Config writes are always accepted.
// Depends on pfc_pkg, pfc_if, pfc_expand, pfc_luma and pfc_pack.
module pixel_format_converter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfc_cfg_if.sink   i_cfg,
    pfc_in_if.sink    i_src,
    pfc_out_if.source o_dst
);
    import pfc_pkg::*;

    t_cfg  r_cfg;
    t_cfg  n_cfg;
    logic  w_a_valid;
    logic  w_a_ready;
    t_rgba w_a_px;
    logic  w_c_valid;
    logic  w_c_ready;
    t_luma w_c_luma;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SOURCE_FORMAT: n_cfg.src_fmt = t_fmt'(i_cfg.data);
                REG_DEST_FORMAT:   n_cfg.dst_fmt = t_fmt'(i_cfg.data);
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_fmt <= FMT_A8R8G8B8;
            r_cfg.dst_fmt <= FMT_A8R8G8B8;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pfc_expand u_expand (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_src_fmt (r_cfg.src_fmt),
        .s_in      (i_src),
        .o_valid   (w_a_valid),
        .i_ready   (w_a_ready),
        .o_px      (w_a_px)
    );

    pfc_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_a_valid),
        .o_ready (w_a_ready),
        .i_px    (w_a_px),
        .o_valid (w_c_valid),
        .i_ready (w_c_ready),
        .o_luma  (w_c_luma)
    );

    pfc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_c_valid),
        .o_ready (w_c_ready),
        .i_luma  (w_c_luma),
        .m_out   (o_dst)
    );

endmodule

@@ rtl/pfc_expand.sv @@
// Stage A: unpack the source pixel and expand it to 8-bit R, G, B, A.
// Depends on pfc_pkg and pfc_in_if.
module pfc_expand (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pfc_pkg::t_fmt   i_src_fmt,
    pfc_in_if.sink          s_in,
    output logic            o_valid,
    input  logic            i_ready,
    output pfc_pkg::t_rgba  o_px
);
    import pfc_pkg::*;

    logic        r_valid;
    t_rgba       r_px;
    t_rgba       n_px;
    logic        w_adv;
    logic [15:0] w_h;

    assign w_adv      = !r_valid || i_ready;
    assign s_in.ready = w_adv;
    assign w_h        = s_in.src_pixel[15:0];

    always_comb begin
        n_px       = '0;
        n_px.a     = 8'd255;
        n_px.pixel = s_in.src_pixel;
        n_px.last  = s_in.last_in;
        case (i_src_fmt)
            FMT_A8R8G8B8: begin
                n_px.b = s_in.src_pixel[7:0];
                n_px.g = s_in.src_pixel[15:8];
                n_px.r = s_in.src_pixel[23:16];
                n_px.a = s_in.src_pixel[31:24];
            end
            FMT_X8R8G8B8, FMT_R8G8B8: begin
                n_px.b = s_in.src_pixel[7:0];
                n_px.g = s_in.src_pixel[15:8];
                n_px.r = s_in.src_pixel[23:16];
            end
            FMT_R5G6B5: begin
                n_px.r = expand5(w_h[15:11]);
                n_px.g = expand6(w_h[10:5]);
                n_px.b = expand5(w_h[4:0]);
            end
            FMT_A1R5G5B5, FMT_X1R5G5B5: begin
                n_px.r = expand5(w_h[14:10]);
                n_px.g = expand5(w_h[9:5]);
                n_px.b = expand5(w_h[4:0]);
                if (i_src_fmt == FMT_A1R5G5B5) begin
                    n_px.a = w_h[15] ? 8'd255 : 8'd0;
                end
            end
            FMT_A4R4G4B4: begin
                n_px.r = expand4(w_h[11:8]);
                n_px.g = expand4(w_h[7:4]);
                n_px.b = expand4(w_h[3:0]);
                n_px.a = expand4(w_h[15:12]);
            end
            FMT_A8: begin
                n_px.r = 8'd255;
                n_px.g = 8'd255;
                n_px.b = 8'd255;
                n_px.a = s_in.src_pixel[7:0];
            end
            FMT_L8: begin
                n_px.r = s_in.src_pixel[7:0];
                n_px.g = s_in.src_pixel[7:0];
                n_px.b = s_in.src_pixel[7:0];
            end
            FMT_A8L8: begin
                n_px.r = s_in.src_pixel[7:0];
                n_px.g = s_in.src_pixel[7:0];
                n_px.b = s_in.src_pixel[7:0];
                n_px.a = s_in.src_pixel[15:8];
            end
            default: begin
                n_px.a = 8'd255;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= s_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && s_in.valid) begin
            r_px <= n_px;
        end
    end

    assign o_valid = r_valid;
    assign o_px    = r_px;

endmodule

@@ rtl/pfc_luma.sv @@
// Stages B and C: weighted luminance sum, then divide by 1000 through a
// reciprocal multiply. Depends on pfc_pkg.
module pfc_luma (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pfc_pkg::t_rgba  i_px,
    output logic            o_valid,
    input  logic            i_ready,
    output pfc_pkg::t_luma  o_luma
);
    import pfc_pkg::*;

    logic              r_valid_b;
    t_lsum             r_lsum;
    logic              r_valid_c;
    t_luma             r_luma;
    logic              w_adv_b;
    logic              w_adv_c;
    logic [LUM_SUM_W-1:0] w_sum;
    logic [PROD_W-1:0] w_prod;

    assign w_adv_c = !r_valid_c || i_ready;
    assign w_adv_b = !r_valid_b || w_adv_c;
    assign o_ready = w_adv_b;

    assign w_sum = {10'd0, i_px.r} * 18'd299
                 + {10'd0, i_px.g} * 18'd587
                 + {10'd0, i_px.b} * 18'd114;

    assign w_prod = {RECIP_W'(0), r_lsum.sum} * {LUM_SUM_W'(0), RECIP_1000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
            r_valid_c <= 1'b0;
        end else begin
            if (w_adv_b) begin
                r_valid_b <= i_valid;
            end
            if (w_adv_c) begin
                r_valid_c <= r_valid_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_b && i_valid) begin
            r_lsum.px  <= i_px;
            r_lsum.sum <= w_sum;
        end
        if (w_adv_c && r_valid_b) begin
            r_luma.px  <= r_lsum.px;
            r_luma.lum <= w_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    assign o_valid = r_valid_c;
    assign o_luma  = r_luma;

endmodule

@@ rtl/pfc_pack.sv @@
// Stage D: pack into the destination format and hold the result in the
// output register. Depends on pfc_pkg and pfc_out_if.
module pfc_pack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pfc_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  pfc_pkg::t_luma  i_luma,
    pfc_out_if.source       m_out
);
    import pfc_pkg::*;

    logic               r_valid;
    logic [PIXEL_W-1:0] r_pixel;
    logic [BYTES_W-1:0] r_bytes;
    logic               r_written;
    logic               r_last;
    logic [PIXEL_W-1:0] n_pixel;
    logic [BYTES_W-1:0] n_bytes;
    logic               n_written;
    logic               w_adv;
    t_rgba              w_px;

    function automatic logic [PIXEL_W-1:0] size_mask(input logic [BYTES_W-1:0] n);
        case (n)
            3'd1:    return 32'h0000_00FF;
            3'd2:    return 32'h0000_FFFF;
            3'd3:    return 32'h00FF_FFFF;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    assign w_adv   = !r_valid || m_out.ready;
    assign o_ready = w_adv;
    assign w_px    = i_luma.px;

    always_comb begin
        n_bytes   = fmt_size(i_cfg.dst_fmt);
        n_pixel   = '0;
        n_written = 1'b0;
        if (n_bytes == 3'd0) begin
            n_written = 1'b0;
        end else if (i_cfg.src_fmt == i_cfg.dst_fmt) begin
            n_pixel   = w_px.pixel & size_mask(n_bytes);
            n_written = 1'b1;
        end else begin
            n_written = 1'b1;
            case (i_cfg.dst_fmt)
                FMT_A8R8G8B8: n_pixel = {w_px.a, w_px.r, w_px.g, w_px.b};
                FMT_X8R8G8B8: n_pixel = {8'd255, w_px.r, w_px.g, w_px.b};
                FMT_R8G8B8:   n_pixel = {8'd0, w_px.r, w_px.g, w_px.b};
                FMT_R5G6B5:   n_pixel = {16'd0, w_px.r[7:3], w_px.g[7:2], w_px.b[7:3]};
                FMT_A1R5G5B5: n_pixel = {16'd0, (w_px.a != 8'd0), w_px.r[7:3],
                                         w_px.g[7:3], w_px.b[7:3]};
                FMT_A4R4G4B4: n_pixel = {16'd0, w_px.a[7:4], w_px.r[7:4],
                                         w_px.g[7:4], w_px.b[7:4]};
                FMT_A8:       n_pixel = {24'd0, w_px.a};
                FMT_L8:       n_pixel = {24'd0, i_luma.lum};
                FMT_A8L8:     n_pixel = {16'd0, w_px.a, i_luma.lum};
                default: begin
                    // no packing rule: flag and write nothing
                    n_pixel   = '0;
                    n_written = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_pixel   <= n_pixel;
            r_bytes   <= n_bytes;
            r_written <= n_written;
            r_last    <= w_px.last;
        end
    end

    assign m_out.valid       = r_valid;
    assign m_out.dst_pixel   = r_pixel;
    assign m_out.dst_bytes   = r_bytes;
    assign m_out.dst_written = r_written;
    assign m_out.last_out    = r_last;

    a_written_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_written |-> r_bytes != 3'd0)
        else $error("written pixel with zero byte count");

    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_written |-> r_pixel == '0)
        else $error("unwritten pixel carries data");

    a_two_byte_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_bytes == 3'd2 |-> r_pixel[31:16] == 16'd0)
        else $error("bytes beyond a two-byte pixel not zero");

    a_one_byte_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_bytes == 3'd1 |-> r_pixel[31:8] == 24'd0)
        else $error("bytes beyond a one-byte pixel not zero");

    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && w_adv |=> r_valid)
        else $error("accepted transaction lost at output register");

endmodule

@@ tb/tb_pixel_format_converter.sv @@
// Self-checking testbench for pixel_format_converter: directed and random pixels
// over many source/destination format pairs, checked against a predictor.
// Depends on pfc_pkg and the channel interfaces in pfc_if.
module tb_pixel_format_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    // Codes above the last defined format have no expansion or packing rule.
    localparam logic [FMT_W-1:0] FMT_UNKNOWN_LO = 4'd10;
    localparam logic [FMT_W-1:0] FMT_UNKNOWN_HI = 4'd15;
    localparam int RANDOM_PIXELS = 850;
    localparam int MAX_IDLE      = 5;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic [BYTES_W-1:0] nbytes;
        logic               written;
        logic               last;
    } pixel_result_t;

    class conversion_scoreboard;
        logic [FMT_W-1:0] src_fmt;
        logic [FMT_W-1:0] dst_fmt;
        pixel_result_t    expected_q[$];
        int               errors;

        function new();
            src_fmt = FMT_A8R8G8B8;
            dst_fmt = FMT_A8R8G8B8;
            errors  = 0;
        endfunction

        function void set_format(input t_reg_idx idx, input logic [FMT_W-1:0] data);
            if (idx == REG_SOURCE_FORMAT)
                src_fmt = data;
            else if (idx == REG_DEST_FORMAT)
                dst_fmt = data;
        endfunction

        function logic [BYTES_W-1:0] format_bytes(input logic [FMT_W-1:0] f);
            case (f)
                FMT_A8R8G8B8, FMT_X8R8G8B8: return 3'd4;
                FMT_R8G8B8:                 return 3'd3;
                FMT_R5G6B5, FMT_A1R5G5B5, FMT_X1R5G5B5,
                FMT_A4R4G4B4, FMT_A8L8:     return 3'd2;
                FMT_A8, FMT_L8:             return 3'd1;
                default:                    return 3'd0;
            endcase
        endfunction

        // Widen to 8-bit channels with truncating x*255/max scaling.
        function void expand_rgba(input logic [PIXEL_W-1:0] p,
                                  output int unsigned r, output int unsigned g,
                                  output int unsigned b, output int unsigned a);
            int unsigned h;
            h = 32'(p[15:0]);
            r = 0; g = 0; b = 0; a = 255;
            case (src_fmt)
                FMT_A8R8G8B8: begin
                    b = 32'(p[7:0]); g = 32'(p[15:8]); r = 32'(p[23:16]); a = 32'(p[31:24]);
                end
                FMT_X8R8G8B8, FMT_R8G8B8: begin
                    b = 32'(p[7:0]); g = 32'(p[15:8]); r = 32'(p[23:16]);
                end
                FMT_R5G6B5: begin
                    r = ((h >> 11) & 32'h1F) * 255 / 31;
                    g = ((h >> 5) & 32'h3F) * 255 / 63;
                    b = (h & 32'h1F) * 255 / 31;
                end
                FMT_A1R5G5B5, FMT_X1R5G5B5: begin
                    r = ((h >> 10) & 32'h1F) * 255 / 31;
                    g = ((h >> 5) & 32'h1F) * 255 / 31;
                    b = (h & 32'h1F) * 255 / 31;
                    if (src_fmt == FMT_A1R5G5B5)
                        a = p[15] ? 255 : 0;
                end
                FMT_A4R4G4B4: begin
                    r = ((h >> 8) & 32'hF) * 255 / 15;
                    g = ((h >> 4) & 32'hF) * 255 / 15;
                    b = (h & 32'hF) * 255 / 15;
                    a = ((h >> 12) & 32'hF) * 255 / 15;
                end
                FMT_A8: begin
                    r = 255; g = 255; b = 255; a = 32'(p[7:0]);
                end
                FMT_L8: begin
                    r = 32'(p[7:0]); g = 32'(p[7:0]); b = 32'(p[7:0]);
                end
                FMT_A8L8: begin
                    r = 32'(p[7:0]); g = 32'(p[7:0]); b = 32'(p[7:0]); a = 32'(p[15:8]);
                end
                default: ;
            endcase
        endfunction

        function pixel_result_t convert(input logic [PIXEL_W-1:0] p, input logic last);
            pixel_result_t res;
            int unsigned   r, g, b, a, lum, packed_px;
            res.nbytes  = format_bytes(dst_fmt);
            res.last    = last;
            res.pixel   = '0;
            res.written = 1'b0;
            if (res.nbytes == 0) begin
                res.written = 1'b0;
            end else if (src_fmt == dst_fmt) begin
                res.written = 1'b1;
                res.pixel   = (res.nbytes == 4) ? p : p & ((32'd1 << (8 * res.nbytes)) - 1);
            end else begin
                expand_rgba(p, r, g, b, a);
                lum         = (r * 299 + g * 587 + b * 114) / 1000;
                res.written = 1'b1;
                case (dst_fmt)
                    FMT_A8R8G8B8: packed_px = b | (g << 8) | (r << 16) | (a << 24);
                    FMT_X8R8G8B8: packed_px = b | (g << 8) | (r << 16) | (255 << 24);
                    FMT_R8G8B8:   packed_px = b | (g << 8) | (r << 16);
                    FMT_R5G6B5:   packed_px = ((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3);
                    FMT_A1R5G5B5: packed_px = ((a != 0 ? 1 : 0) << 15) | ((r >> 3) << 10)
                                              | ((g >> 3) << 5) | (b >> 3);
                    FMT_A4R4G4B4: packed_px = ((a >> 4) << 12) | ((r >> 4) << 8)
                                              | ((g >> 4) << 4) | (b >> 4);
                    FMT_A8:       packed_px = a;
                    FMT_L8:       packed_px = lum & 32'hFF;
                    FMT_A8L8:     packed_px = (lum & 32'hFF) | (a << 8);
                    default: begin
                        packed_px   = 0;
                        res.written = 1'b0;
                    end
                endcase
                res.pixel = packed_px;
            end
            return res;
        endfunction

        function void note_pixel(input logic [PIXEL_W-1:0] p, input logic last);
            expected_q.push_back(convert(p, last));
        endfunction

        task report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
                             input logic [PIXEL_W-1:0] want);
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_pixel(input logic [PIXEL_W-1:0] pixel, input logic [BYTES_W-1:0] nbytes,
                         input logic written, input logic last);
            pixel_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transaction", pixel, '0);
            end else begin
                want = expected_q.pop_front();
                if (pixel !== want.pixel)
                    report_mismatch("dst_pixel", pixel, want.pixel);
                if (nbytes !== want.nbytes)
                    report_mismatch("dst_bytes", PIXEL_W'(nbytes), PIXEL_W'(want.nbytes));
                if (written !== want.written)
                    report_mismatch("dst_written", PIXEL_W'(written), PIXEL_W'(want.written));
                if (last !== want.last)
                    report_mismatch("last_out", PIXEL_W'(last), PIXEL_W'(want.last));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;

    logic [FMT_W-1:0]     cur_src;
    logic [FMT_W-1:0]     cur_dst;
    conversion_scoreboard sb;

    pfc_cfg_if cfg_bus ();
    pfc_in_if  src_bus ();
    pfc_out_if dst_bus ();

    pixel_format_converter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_src   (src_bus),
        .o_dst   (dst_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Hold ready high between draws; a handshake takes one result transaction.
    initial begin
        int stall;
        dst_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                dst_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            dst_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!dst_bus.valid);
            sb.check_pixel(dst_bus.dst_pixel, dst_bus.dst_bytes,
                           dst_bus.dst_written, dst_bus.last_out);
        end
    end

    // Leaves valid high; the caller lowers it once the last write is done.
    task write_reg(input t_reg_idx idx, input logic [FMT_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.set_format(idx, data);
    endtask

    // Leaves valid high after the transaction; a gap, a format change or the end drops it.
    task send_pixel(input logic [PIXEL_W-1:0] p, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            src_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_bus.valid     <= 1'b1;
        src_bus.src_pixel <= p;
        src_bus.last_in   <= last;
        do @(posedge i_clk); while (!src_bus.ready);
        sb.note_pixel(p, last);
    endtask

    task wait_drained();
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task set_formats(input logic [FMT_W-1:0] sf, input logic [FMT_W-1:0] df);
        src_bus.valid <= 1'b0;
        wait_drained();
        write_reg(REG_SOURCE_FORMAT, sf);
        write_reg(REG_DEST_FORMAT, df);
        cfg_bus.valid <= 1'b0;
        cur_src = sf;
        cur_dst = df;
    endtask

    task run_item(input logic [FMT_W-1:0] sf, input logic [FMT_W-1:0] df,
                  input logic [PIXEL_W-1:0] p, input logic last);
        if (sf !== cur_src || df !== cur_dst)
            set_formats(sf, df);
        send_pixel(p, last);
    endtask

    initial begin
        logic [FMT_W-1:0]   sf;
        logic [FMT_W-1:0]   df;
        logic [PIXEL_W-1:0] p;
        int                 len;
        int                 sent;

        sb = new();
        no_idle = 1'b0;
        i_rst_n           <= 1'b0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= REG_SOURCE_FORMAT;
        cfg_bus.data      <= FMT_A8R8G8B8;
        src_bus.valid     <= 1'b0;
        src_bus.src_pixel <= '0;
        src_bus.last_in   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_formats(FMT_A8R8G8B8, FMT_A8R8G8B8);
        run_item(FMT_A8R8G8B8, FMT_A8R8G8B8, 32'h0000_0000, 1'b0);
        run_item(FMT_A8R8G8B8, FMT_A8R8G8B8, 32'hFFFF_FFFF, 1'b1);
        run_item(FMT_R8G8B8,   FMT_R8G8B8,   32'hFFFF_FFFF, 1'b0);
        run_item(FMT_R5G6B5,   FMT_L8,       32'h0000_FFFF, 1'b0);
        run_item(FMT_R5G6B5,   FMT_L8,       32'hFFFF_0000, 1'b1);
        run_item(FMT_R5G6B5,   FMT_A8R8G8B8, 32'h1234_5A5A, 1'b0);
        run_item(FMT_A1R5G5B5, FMT_A4R4G4B4, 32'h0000_8000, 1'b0);
        run_item(FMT_A1R5G5B5, FMT_A4R4G4B4, 32'hFFFF_7FFF, 1'b1);
        run_item(FMT_X1R5G5B5, FMT_A1R5G5B5, 32'h0000_FFFF, 1'b0);
        run_item(FMT_A4R4G4B4, FMT_X8R8G8B8, 32'h0000_0F0F, 1'b0);
        // A8 source: any nonzero alpha sets the single alpha bit
        run_item(FMT_A8,       FMT_A1R5G5B5, 32'h0000_0000, 1'b0);
        run_item(FMT_A8,       FMT_A1R5G5B5, 32'hFFFF_FF01, 1'b0);
        run_item(FMT_L8,       FMT_R5G6B5,   32'h0000_0080, 1'b0);
        run_item(FMT_A8L8,     FMT_A8R8G8B8, 32'h0000_C040, 1'b0);
        run_item(FMT_A8R8G8B8, FMT_A8L8,     32'hFF10_2030, 1'b0);
        // X1R5G5B5 destination has no packing rule unless formats match
        run_item(FMT_A8R8G8B8, FMT_X1R5G5B5, 32'hFFFF_FFFF, 1'b0);
        run_item(FMT_X1R5G5B5, FMT_X1R5G5B5, 32'hFFFF_FFFF, 1'b0);
        run_item(FMT_UNKNOWN_LO, FMT_A8R8G8B8, 32'h1234_5678, 1'b0);
        run_item(FMT_X8R8G8B8, FMT_UNKNOWN_HI, 32'hFFFF_FFFF, 1'b0);
        run_item(FMT_UNKNOWN_HI, FMT_UNKNOWN_HI, 32'hFFFF_FFFF, 1'b1);
        run_item(FMT_X8R8G8B8, FMT_A8,       32'hAB00_0000, 1'b0);
        run_item(FMT_A8R8G8B8, FMT_X8R8G8B8, 32'h0012_3456, 1'b0);
        run_item(FMT_R8G8B8,   FMT_A8,       32'h5AA5_C33C, 1'b1);

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    sf = FMT_W'($urandom_range(FMT_A8R8G8B8, FMT_A8L8));
                    df = sf;
                end
                2: begin
                    sf = FMT_W'($urandom_range(FMT_A8R8G8B8, FMT_UNKNOWN_HI));
                    df = FMT_W'($urandom_range(FMT_A8R8G8B8, FMT_UNKNOWN_HI));
                end
                default: begin
                    sf = FMT_W'($urandom_range(FMT_A8R8G8B8, FMT_A8L8));
                    df = FMT_W'($urandom_range(FMT_A8R8G8B8, FMT_A8L8));
                end
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            len = $urandom_range(5, 40);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 7))
                    0:       p = '0;
                    1:       p = '1;
                    default: p = $urandom;
                endcase
                run_item(sf, df, p, (k == len - 1) || ($urandom_range(0, 15) == 0));
            end
            sent += len;
        end

        src_bus.valid <= 1'b0;
        no_idle = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pfc_pkg.sv
rtl/pfc_if.sv
rtl/pfc_expand.sv
rtl/pfc_luma.sv
rtl/pfc_pack.sv
rtl/pixel_format_converter.sv
tb/tb_pixel_format_converter.sv
